@@ sv/tavg_pkg.sv @@
// ----------------------------------------------------------------------------
// tavg_pkg
// Types and constants shared by the trimmed battery average blocks.
// ----------------------------------------------------------------------------
package tavg_pkg;

   localparam int SAMPLE_BITS = 8;
   localparam int AVG_BITS    = 8;
   localparam int AVG_SHIFT   = 3;
   localparam int NUM_CHAN    = 3;
   localparam int NUM_THRESH  = 5;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] LEVEL_MAX = 3'd5;

   // CSR indexes
   localparam logic [2:0] REG_THRESH_0    = 3'd0;
   localparam logic [2:0] REG_THRESH_1    = 3'd1;
   localparam logic [2:0] REG_THRESH_2    = 3'd2;
   localparam logic [2:0] REG_THRESH_3    = 3'd3;
   localparam logic [2:0] REG_THRESH_4    = 3'd4;
   localparam logic [2:0] REG_CUR_LIMIT   = 3'd5;
   localparam logic [2:0] REG_OVL_BLOCKS  = 3'd6;
   localparam logic [2:0] REG_LOW_MARK    = 3'd7;

   localparam logic [7:0] CUR_LIMIT_RESET  = 8'd255;
   localparam logic [5:0] OVL_BLOCKS_RESET = 6'd50;
   localparam logic [2:0] LOW_MARK_RESET   = 3'd2;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] current_sample;
      logic [SAMPLE_BITS-1:0] battery_sample;
      logic [SAMPLE_BITS-1:0] output_sample;
      logic                   charging;
      logic                   input_present;
      logic                   output_enabled;
      logic                   low_timer_idle;
   } req_type;

   typedef struct packed {
      logic                block_done;
      logic [AVG_BITS-1:0] current_avg;
      logic [AVG_BITS-1:0] battery_avg;
      logic [AVG_BITS-1:0] output_avg;
      logic [2:0]          battery_level;
      logic                empty_flag;
      logic                low_flag;
      logic                display_low;
      logic                cutoff_request;
      logic                restart_low_timer;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_ACCUM
   } phase_type;

   // tagged beat held in the queue
   typedef struct packed {
      req_type   req;
      phase_type phase;
      logic      last;
   } work_type;

   // accumulate stage to level stage
   typedef struct packed {
      logic                               valid;
      logic                               done;
      logic                               charging;
      logic                               input_present;
      logic                               output_enabled;
      logic                               timer_idle;
      logic [NUM_CHAN-1:0][AVG_BITS-1:0]  avg;
   } acc_type;

   typedef struct packed {
      logic [NUM_THRESH-1:0][7:0] thresh;
      logic [7:0]                 current_limit;
      logic [5:0]                 overload_blocks;
      logic [2:0]                 low_level_mark;
   } cfg_type;

endpackage

@@ sv/tavg_front.sv @@
// ----------------------------------------------------------------------------
// tavg_front
// Takes round beats, tracks the round within the block and tags each beat.
// ----------------------------------------------------------------------------
module tavg_front import tavg_pkg::*; #(
   parameter int ROUNDS_PER_BLOCK = 10
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     push_valid,
   input  logic     push_ready,
   output work_type push_data
);

   localparam int RCW = $clog2(ROUNDS_PER_BLOCK);

   logic [RCW-1:0] round_ff, round_in;
   logic           last;

   assign last       = (round_ff == RCW'(ROUNDS_PER_BLOCK - 1));
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   always_comb begin
      push_data.req  = req_data;
      push_data.last = last;
      if (round_ff == RCW'(0)) begin
         push_data.phase = PH_FIRST;
      end else if (round_ff == RCW'(1)) begin
         push_data.phase = PH_SECOND;
      end else begin
         push_data.phase = PH_ACCUM;
      end
      round_in = last ? RCW'(0) : round_ff + RCW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= '0;
      end else if (req_valid && push_ready) begin
         round_ff <= round_in;
      end
   end

endmodule

@@ sv/tavg_queue.sv @@
// ----------------------------------------------------------------------------
// tavg_queue
// Small queue of tagged beats between the front and the back end.
// ----------------------------------------------------------------------------
module tavg_queue import tavg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  work_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output work_type pop_data
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   work_type       mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ff, rd_ff;
   logic [CW-1:0]  count_ff;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != CW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != CW'(0));
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PW'(QUEUE_DEPTH - 1)) ? PW'(0) : wr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PW'(QUEUE_DEPTH - 1)) ? PW'(0) : rd_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

@@ sv/tavg_accum.sv @@
// ----------------------------------------------------------------------------
// tavg_accum
// Per-channel running min/max and trimmed sum; closes averages per block.
// ----------------------------------------------------------------------------
module tavg_accum import tavg_pkg::*; #(
   parameter int ROUNDS_PER_BLOCK = 10
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     pop_valid,
   output logic     pop_ready,
   input  work_type pop_data,
   output acc_type  acc,
   input  logic     acc_ready
);

   localparam int CW    = $clog2(ROUNDS_PER_BLOCK);
   localparam int SUM_W = SAMPLE_BITS + ((CW > AVG_SHIFT) ? CW : AVG_SHIFT + 1);

   logic [SAMPLE_BITS-1:0] min_ff [NUM_CHAN];
   logic [SAMPLE_BITS-1:0] min_in [NUM_CHAN];
   logic [SAMPLE_BITS-1:0] max_ff [NUM_CHAN];
   logic [SAMPLE_BITS-1:0] max_in [NUM_CHAN];
   logic [SUM_W-1:0]       sum_ff [NUM_CHAN];
   logic [SUM_W-1:0]       sum_in [NUM_CHAN];
   logic [AVG_BITS-1:0]    avg_ff [NUM_CHAN];
   logic [AVG_BITS-1:0]    avg_in [NUM_CHAN];
   logic [SAMPLE_BITS-1:0] smp    [NUM_CHAN];
   logic                   valid_ff;
   logic                   done_ff, chg_ff, inp_ff, oen_ff, idle_ff;
   logic                   take;

   assign pop_ready = !valid_ff || acc_ready;
   assign take      = pop_valid && pop_ready;

   assign smp[0] = pop_data.req.current_sample;
   assign smp[1] = pop_data.req.battery_sample;
   assign smp[2] = pop_data.req.output_sample;

   always_comb begin
      logic [SAMPLE_BITS-1:0]     pushed;
      logic [SUM_W-1:0]           total;
      logic [SUM_W-AVG_SHIFT-1:0] full;
      for (int c = 0; c < NUM_CHAN; c++) begin
         min_in[c] = min_ff[c];
         max_in[c] = max_ff[c];
         sum_in[c] = sum_ff[c];
         avg_in[c] = avg_ff[c];
         pushed    = smp[c];
         if (smp[c] > max_ff[c]) begin
            pushed = max_ff[c];
         end else if (smp[c] < min_ff[c]) begin
            pushed = min_ff[c];
         end
         total = sum_ff[c] + SUM_W'(pushed);
         full  = total[SUM_W-1:AVG_SHIFT];
         case (pop_data.phase)
            PH_FIRST: begin
               min_in[c] = smp[c];
               max_in[c] = smp[c];
            end
            PH_SECOND: begin
               if (smp[c] < min_ff[c]) begin
                  min_in[c] = smp[c];
               end else if (smp[c] > max_ff[c]) begin
                  max_in[c] = smp[c];
               end
            end
            default: begin
               if (smp[c] > max_ff[c]) begin
                  max_in[c] = smp[c];
               end
               if (smp[c] < min_ff[c]) begin
                  min_in[c] = smp[c];
               end
               sum_in[c] = total;
            end
         endcase
         if (pop_data.last) begin
            sum_in[c] = '0;
            avg_in[c] = (|full[SUM_W-AVG_SHIFT-1:AVG_BITS]) ? '1 : full[AVG_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CHAN; c++) begin
            min_ff[c] <= '0;
            max_ff[c] <= '0;
            sum_ff[c] <= '0;
            avg_ff[c] <= '0;
         end
      end else begin
         if (take) begin
            valid_ff <= 1'b1;
            for (int c = 0; c < NUM_CHAN; c++) begin
               min_ff[c] <= min_in[c];
               max_ff[c] <= max_in[c];
               sum_ff[c] <= sum_in[c];
               avg_ff[c] <= avg_in[c];
            end
         end else if (acc_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         done_ff <= pop_data.last;
         chg_ff  <= pop_data.req.charging;
         inp_ff  <= pop_data.req.input_present;
         oen_ff  <= pop_data.req.output_enabled;
         idle_ff <= pop_data.req.low_timer_idle;
      end
   end

   always_comb begin
      acc.valid          = valid_ff;
      acc.done           = done_ff;
      acc.charging       = chg_ff;
      acc.input_present  = inp_ff;
      acc.output_enabled = oen_ff;
      acc.timer_idle     = idle_ff;
      for (int c = 0; c < NUM_CHAN; c++) begin
         acc.avg[c] = avg_ff[c];
      end
   end

endmodule

@@ sv/tavg_level.sv @@
// ----------------------------------------------------------------------------
// tavg_level
// Battery level classification, overload count, low flags; result register.
// ----------------------------------------------------------------------------
module tavg_level import tavg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  acc_type acc,
   output logic    acc_ready,
   input  cfg_type cfg,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [2:0] level_ff, level_in;
   logic [5:0] ovl_ff, ovl_in;
   logic [2:0] flags_ff, flags_in;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff, rsp_in;
   logic       load;

   assign acc_ready = !rsp_valid_ff || rsp_ready;
   assign load      = acc.valid && acc_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic [2:0] cls;
      logic [2:0] mark;
      logic [6:0] cnt;
      logic       cut;
      logic       rst;
      level_in = level_ff;
      ovl_in   = ovl_ff;
      flags_in = flags_ff;
      cut      = 1'b0;
      rst      = 1'b0;
      cls      = LEVEL_MAX;
      mark     = (cfg.low_level_mark > LEVEL_MAX) ? LEVEL_MAX : cfg.low_level_mark;
      cnt      = {1'b0, ovl_ff} + 7'd1;
      for (int i = NUM_THRESH - 1; i >= 0; i--) begin
         if (acc.avg[1] <= cfg.thresh[i]) begin
            cls = 3'(i);
         end
      end
      if (acc.done) begin
         if (acc.charging) begin
            if (acc.avg[0] > cfg.current_limit) begin
               if (cnt > {1'b0, cfg.overload_blocks}) begin
                  cut = 1'b1;
               end else begin
                  ovl_in = cnt[5:0];
               end
            end else begin
               ovl_in = '0;
            end
         end
         if (acc.charging) begin
            if (level_ff < cls) begin
               level_in = cls;
            end
         end else if (acc.input_present) begin
            if (level_ff > cls) begin
               level_in = cls;
            end
         end else begin
            level_in = cls;
         end
         if (acc.input_present) begin
            if (level_in < mark) begin
               level_in = mark;
            end
         end else if (level_in == 3'd0) begin
            flags_in[1:0] = 2'b11;
            if (acc.output_enabled && acc.timer_idle) begin
               cut = 1'b1;
            end
         end else begin
            flags_in[0] = 1'b0;
            if (level_in > mark) begin
               flags_in[2:1] = 2'b00;
            end else begin
               flags_in[2:1] = 2'b11;
               rst = 1'b1;
            end
         end
      end
      rsp_in.block_done        = acc.done;
      rsp_in.current_avg       = acc.avg[0];
      rsp_in.battery_avg       = acc.avg[1];
      rsp_in.output_avg        = acc.avg[2];
      rsp_in.battery_level     = level_in;
      rsp_in.empty_flag        = flags_in[0];
      rsp_in.low_flag          = flags_in[1];
      rsp_in.display_low       = flags_in[2];
      rsp_in.cutoff_request    = cut;
      rsp_in.restart_low_timer = rst;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         ovl_ff       <= '0;
         flags_ff     <= '0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
         level_ff     <= level_in;
         ovl_ff       <= ovl_in;
         flags_ff     <= flags_in;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ sv/trimmed_adc_average_battery_level.sv @@
// Battery monitor with a trimmed (olympic) average. Each request beat is one
// round of three ADC samples plus power flags and yields exactly one response
// beat. Every ROUNDS_PER_BLOCK rounds the response carries block_done and the
// new averages (sum of the middle samples shifted right by three), the kept
// battery level, low-battery flags, the cutoff request and the timer restart.
// The block sustains one beat per clock while rsp_ready stays high: a front
// stage tags the round, a two-entry queue decouples it from the accumulate
// register and the level stage, which writes the response register.
// Configuration must be written over the APB port by the user only while no
// beats are in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
// trimmed_adc_average_battery_level
// Top level: CSRs, front tagger, queue, accumulator and level stage.
// ----------------------------------------------------------------------------
module trimmed_adc_average_battery_level import tavg_pkg::*; #(
   parameter int ROUNDS_PER_BLOCK = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type  cfg_ff;
   logic     cfg_wr;
   logic [2:0] reg_idx;

   logic     push_valid, push_ready, pop_valid, pop_ready, acc_ready;
   work_type push_data, pop_data;
   acc_type  acc;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign cfg_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thresh          <= '0;
         cfg_ff.current_limit   <= CUR_LIMIT_RESET;
         cfg_ff.overload_blocks <= OVL_BLOCKS_RESET;
         cfg_ff.low_level_mark  <= LOW_MARK_RESET;
      end else if (cfg_wr) begin
         case (reg_idx)
            REG_THRESH_0:   cfg_ff.thresh[0]       <= pwdata[7:0];
            REG_THRESH_1:   cfg_ff.thresh[1]       <= pwdata[7:0];
            REG_THRESH_2:   cfg_ff.thresh[2]       <= pwdata[7:0];
            REG_THRESH_3:   cfg_ff.thresh[3]       <= pwdata[7:0];
            REG_THRESH_4:   cfg_ff.thresh[4]       <= pwdata[7:0];
            REG_CUR_LIMIT:  cfg_ff.current_limit   <= pwdata[7:0];
            REG_OVL_BLOCKS: cfg_ff.overload_blocks <= pwdata[5:0];
            REG_LOW_MARK:   cfg_ff.low_level_mark  <= pwdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_THRESH_0:   prdata = {24'd0, cfg_ff.thresh[0]};
         REG_THRESH_1:   prdata = {24'd0, cfg_ff.thresh[1]};
         REG_THRESH_2:   prdata = {24'd0, cfg_ff.thresh[2]};
         REG_THRESH_3:   prdata = {24'd0, cfg_ff.thresh[3]};
         REG_THRESH_4:   prdata = {24'd0, cfg_ff.thresh[4]};
         REG_CUR_LIMIT:  prdata = {24'd0, cfg_ff.current_limit};
         REG_OVL_BLOCKS: prdata = {26'd0, cfg_ff.overload_blocks};
         REG_LOW_MARK:   prdata = {29'd0, cfg_ff.low_level_mark};
         default:        prdata = '0;
      endcase
   end

   tavg_front #(
      .ROUNDS_PER_BLOCK (ROUNDS_PER_BLOCK)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   tavg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   tavg_accum #(
      .ROUNDS_PER_BLOCK (ROUNDS_PER_BLOCK)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .acc       (acc),
      .acc_ready (acc_ready)
   );

   tavg_level u_level (
      .clock     (clock),
      .reset     (reset),
      .acc       (acc),
      .acc_ready (acc_ready),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ dv/trimmed_adc_average_battery_level_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trimmed_adc_average_battery_level_test
// Self-checking bench for the trimmed-average battery monitor. Rounds of
// three samples are sent in ten-round blocks with random levels and spread.
// A local predictor tracks min/max/sum, the kept level, the overload count
// and the low-battery flags. Every response beat is compared field by field.
// Phases change the CSRs over APB and the amount of sender and receiver idling.
// ----------------------------------------------------------------------------
module trimmed_adc_average_battery_level_test;
   import tavg_pkg::*;

   localparam int ROUNDS         = 10;
   localparam int WATCHDOG_LIMIT = 3000;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel      = 1'b0;
   logic        penable   = 1'b0;
   logic        pwrite    = 1'b0;
   logic [4:0]  paddr     = '0;
   logic [31:0] pwdata    = '0;
   logic [31:0] prdata;
   logic        pready;

   trimmed_adc_average_battery_level uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // CSR copy
   logic [7:0] bat_thresh [NUM_THRESH] = '{default: 8'd0};
   logic [7:0] cur_limit  = CUR_LIMIT_RESET;
   logic [5:0] ovl_blocks = OVL_BLOCKS_RESET;
   logic [2:0] low_mark   = LOW_MARK_RESET;

   // monitor state copy
   int         round_no = 0;
   int         ch_lo  [NUM_CHAN] = '{default: 0};
   int         ch_hi  [NUM_CHAN] = '{default: 0};
   int         ch_sum [NUM_CHAN] = '{default: 0};
   logic [7:0] ch_avg [NUM_CHAN] = '{default: 8'd0};
   logic [2:0] level_kept = '0;
   int         ovl_count  = 0;
   logic [2:0] low_bits   = '0;   // bit0 empty, bit1 low, bit2 display

   req_type rounds_to_send [$];
   rsp_type rounds_due [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit send_pause    = 1'b0;
   int rsp_hold_req  = 0;
   int rsp_hold_left = 0;
   int mismatches    = 0;
   int stall_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_type predict_round(req_type r);
      rsp_type    o;
      int         smp [NUM_CHAN];
      int         pushed;
      int         mark;
      int         c;
      int         ch;
      int         i;
      logic [2:0] cls;
      bit         found;
      bit         done;
      bit         cut;
      bit         rst;
      smp[0] = int'(r.current_sample);
      smp[1] = int'(r.battery_sample);
      smp[2] = int'(r.output_sample);
      done = 0;
      cut  = 0;
      rst  = 0;
      for (ch = 0; ch < NUM_CHAN; ch++) begin
         if (round_no == 0) begin
            ch_lo[ch] = smp[ch];
            ch_hi[ch] = smp[ch];
         end else if (round_no == 1) begin
            if (smp[ch] < ch_lo[ch]) ch_lo[ch] = smp[ch];
            else if (smp[ch] > ch_hi[ch]) ch_hi[ch] = smp[ch];
         end else begin
            pushed = smp[ch];
            if (smp[ch] > ch_hi[ch]) begin
               pushed = ch_hi[ch];
               ch_hi[ch] = smp[ch];
            end
            if (smp[ch] < ch_lo[ch]) begin
               pushed = ch_lo[ch];
               ch_lo[ch] = smp[ch];
            end
            ch_sum[ch] += pushed;
         end
      end
      round_no++;
      if (round_no >= ROUNDS) begin
         done = 1;
         round_no = 0;
         for (ch = 0; ch < NUM_CHAN; ch++) begin
            c = ch_sum[ch] >> AVG_SHIFT;
            ch_avg[ch] = (c > 255) ? 8'd255 : c[7:0];
            ch_sum[ch] = 0;
         end
         mark = int'((low_mark > LEVEL_MAX) ? LEVEL_MAX : low_mark);
         if (r.charging) begin
            if (ch_avg[0] > cur_limit) begin
               c = ovl_count + 1;
               if (c > ovl_blocks) begin
                  c--;
                  cut = 1;
               end
               ovl_count = c & 63;
            end else begin
               ovl_count = 0;
            end
         end
         cls = LEVEL_MAX;
         found = 0;
         for (i = 0; i < NUM_THRESH; i++) begin
            if (!found && ch_avg[1] <= bat_thresh[i]) begin
               cls = 3'(i);
               found = 1;
            end
         end
         if (r.charging) begin
            if (level_kept < cls) level_kept = cls;
         end else if (r.input_present) begin
            if (level_kept > cls) level_kept = cls;
         end else begin
            level_kept = cls;
         end
         if (r.input_present) begin
            if (level_kept < mark) level_kept = 3'(mark);
         end else if (level_kept == 0) begin
            low_bits |= 3'b011;
            if (r.output_enabled && r.low_timer_idle) cut = 1;
         end else begin
            low_bits[0] = 1'b0;
            if (level_kept > mark) begin
               low_bits[2:1] = 2'b00;
            end else begin
               low_bits[2:1] = 2'b11;
               rst = 1;
            end
         end
      end
      o.block_done        = done;
      o.current_avg       = ch_avg[0];
      o.battery_avg       = ch_avg[1];
      o.output_avg        = ch_avg[2];
      o.battery_level     = level_kept;
      o.empty_flag        = low_bits[0];
      o.low_flag          = low_bits[1];
      o.display_low       = low_bits[2];
      o.cutoff_request    = cut;
      o.restart_low_timer = rst;
      return o;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t rsp %s: expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            rounds_due.push_back(predict_round(req_data));
            void'(rounds_to_send.pop_front());
         end
         if (!req_valid || req_ready) begin
            if (rounds_to_send.size() != 0 && !send_pause &&
                $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= rounds_to_send[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rounds_due.size() == 0) begin
               $display("%0t rsp beat: expected none, got %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = rounds_due.pop_front();
               check_field("block_done", 8'(want.block_done),
                           8'(rsp_data.block_done));
               check_field("current_avg", want.current_avg, rsp_data.current_avg);
               check_field("battery_avg", want.battery_avg, rsp_data.battery_avg);
               check_field("output_avg", want.output_avg, rsp_data.output_avg);
               check_field("battery_level", 8'(want.battery_level),
                           8'(rsp_data.battery_level));
               check_field("empty_flag", 8'(want.empty_flag),
                           8'(rsp_data.empty_flag));
               check_field("low_flag", 8'(want.low_flag), 8'(rsp_data.low_flag));
               check_field("display_low", 8'(want.display_low),
                           8'(rsp_data.display_low));
               check_field("cutoff_request", 8'(want.cutoff_request),
                           8'(rsp_data.cutoff_request));
               check_field("restart_low_timer", 8'(want.restart_low_timer),
                           8'(rsp_data.restart_low_timer));
            end
         end
         if (rsp_hold_req != 0) begin
            rsp_hold_left = rsp_hold_req;
            rsp_hold_req  = 0;
         end
         if (rsp_hold_left != 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("trimmed_adc_average_battery_level_test: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [7:0] val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_CUR_LIMIT:  cur_limit  = val;
         REG_OVL_BLOCKS: ovl_blocks = val[5:0];
         REG_LOW_MARK:   low_mark   = val[2:0];
         default:        bat_thresh[idx] = val;
      endcase
   endtask

   task automatic set_config(logic [7:0] t0, logic [7:0] t1, logic [7:0] t2,
                             logic [7:0] t3, logic [7:0] t4, logic [7:0] limit,
                             logic [7:0] ovl, logic [7:0] mark);
      write_reg(REG_THRESH_0, t0);
      write_reg(REG_THRESH_1, t1);
      write_reg(REG_THRESH_2, t2);
      write_reg(REG_THRESH_3, t3);
      write_reg(REG_THRESH_4, t4);
      write_reg(REG_CUR_LIMIT, limit);
      write_reg(REG_OVL_BLOCKS, ovl);
      write_reg(REG_LOW_MARK, mark);
   endtask

   task automatic add_round(int cur, int bat, int outv, logic [3:0] flags);
      req_type r;
      r.current_sample = 8'(cur);
      r.battery_sample = 8'(bat);
      r.output_sample  = 8'(outv);
      {r.charging, r.input_present, r.output_enabled, r.low_timer_idle} = flags;
      rounds_to_send.push_back(r);
   endtask

   // each block has its own level and spread per channel, flags mostly steady
   task automatic add_random_blocks(int count);
      int         base   [NUM_CHAN];
      int         spread [NUM_CHAN];
      int         smp    [NUM_CHAN];
      int         ch;
      int         i;
      logic [3:0] mode;
      logic [3:0] flags;
      repeat (count) begin
         for (ch = 0; ch < NUM_CHAN; ch++) begin
            base[ch]   = $urandom_range(255);
            spread[ch] = ($urandom_range(3) == 0) ? 255 : $urandom_range(40);
         end
         mode = 4'($urandom_range(15));
         for (i = 0; i < ROUNDS; i++) begin
            for (ch = 0; ch < NUM_CHAN; ch++) begin
               smp[ch] = base[ch] + int'($urandom_range(2 * spread[ch])) - spread[ch];
               if (smp[ch] < 0) smp[ch] = 0;
               if (smp[ch] > 255) smp[ch] = 255;
            end
            flags = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : mode;
            add_round(smp[0], smp[1], smp[2], flags);
         end
      end
   endtask

   task automatic wait_idle();
      while (rounds_to_send.size() != 0 || req_valid || rounds_due.size() != 0)
         @(posedge clock);
   endtask

   initial begin : sequencer
      int i;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: full-scale current with zero overload tolerance, repeated
      // samples, mark above five, then an empty battery with output on
      set_config(8'd30, 8'd60, 8'd90, 8'd120, 8'd150, 8'd0, 8'd0, 8'd7);
      for (i = 0; i < ROUNDS; i++)
         add_round(255, 100, (i == 0) ? 0 : (i == 1) ? 255 : i * 25, 4'b1011);
      for (i = 0; i < ROUNDS; i++)
         add_round(0, 0, 255 - i * 20, (i % 2 == 0) ? 4'b0111 : 4'b0011);
      wait_idle();

      set_config(8'd40, 8'd80, 8'd120, 8'd160, 8'd200, 8'd128, 8'd2, 8'd2);
      add_random_blocks(30);
      wait_idle();

      send_idle_pct = 66;
      set_config(8'd200, 8'd50, 8'd255, 8'd0, 8'd100, 8'd255, 8'd63, 8'd0);
      add_random_blocks(30);
      wait_idle();

      // long receiver hold-off while the sender keeps offering
      send_idle_pct = 0;
      rsp_stall_pct = 66;
      set_config(8'd10, 8'd60, 8'd110, 8'd170, 8'd230, 8'd60, 8'd1, 8'd5);
      add_random_blocks(40);
      rsp_hold_req = 300;
      wait_idle();

      // sender pauses midway until all responses are back
      send_idle_pct = 29;
      rsp_stall_pct = 29;
      set_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd6);
      add_random_blocks(30);
      while (rounds_to_send.size() > 150) @(posedge clock);
      send_pause = 1'b1;
      while (req_valid || rounds_due.size() != 0) @(posedge clock);
      send_pause = 1'b0;
      wait_idle();

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_config(8'd25, 8'd75, 8'd125, 8'd175, 8'd225, 8'd100, 8'd3, 8'd3);
      add_random_blocks(60);
      wait_idle();

      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("trimmed_adc_average_battery_level_test: clean");
      end else begin
         $display("trimmed_adc_average_battery_level_test: errors");
      end
      $finish;
   end

endmodule

@@ trimmed_adc_average_battery_level.f @@
sv/tavg_pkg.sv
sv/tavg_front.sv
sv/tavg_queue.sv
sv/tavg_accum.sv
sv/tavg_level.sv
sv/trimmed_adc_average_battery_level.sv
dv/trimmed_adc_average_battery_level_test.sv
